// ----- design/dfr_pkg.sv -----
// Shared types and constants of the delimited frame receiver.
`default_nettype none

package dfr_pkg;

    // Number of payload bytes held for one frame.
    localparam int unsigned FRAME_BYTES = 6;

    // Width of a byte count that can also hold FRAME_BYTES itself.
    localparam int unsigned COUNT_W = $clog2(FRAME_BYTES + 1);

    // Configuration port geometry.
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_START_CODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_CODE      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_LIMIT = 2'd2;

    // Configuration reset values.
    localparam logic [7:0] START_CODE_RST    = 8'hFD;
    localparam logic [7:0] END_CODE_RST      = 8'hFE;
    localparam logic [7:0] TIMEOUT_LIMIT_RST = 8'd100;

    // Input item kinds.
    localparam logic FUNC_BYTE = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    typedef logic [7:0] t_byte;

    // One handed-over frame.
    typedef struct packed {
        logic                         frame_ready;
        logic [FRAME_BYTES-1:0][7:0]  payload;
    } t_result;

endpackage

`default_nettype wire

// ----- design/dfr_in_if.sv -----
// Input channel of the frame receiver: one received byte or one poll tick.
`default_nettype none

interface dfr_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] rx_byte;

    modport source (output valid, output func, output rx_byte, input ready);
    modport sink   (input valid, input func, input rx_byte, output ready);
endinterface

`default_nettype wire

// ----- design/dfr_out_if.sv -----
// Output channel of the frame receiver: one completed frame.
`default_nettype none

interface dfr_out_if;
    logic       valid;
    logic       ready;
    logic       frame_ready;
    logic [7:0] payload_0;
    logic [7:0] payload_1;
    logic [7:0] payload_2;
    logic [7:0] payload_3;
    logic [7:0] payload_4;
    logic [7:0] payload_5;

    modport source (
        output valid, output frame_ready,
        output payload_0, output payload_1, output payload_2,
        output payload_3, output payload_4, output payload_5,
        input  ready
    );
    modport sink (
        input  valid, input frame_ready,
        input  payload_0, input payload_1, input payload_2,
        input  payload_3, input payload_4, input payload_5,
        output ready
    );
endinterface

`default_nettype wire

// ----- design/dfr_out_buf.sv -----
// Two-entry output buffer (output register plus skid register) for frame results.
`default_nettype none

module dfr_out_buf (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_push,
    input  wire dfr_pkg::t_result i_data,
    output logic              o_ready,
    dfr_out_if.source         o_out
);

    logic             r_out_valid;
    dfr_pkg::t_result r_out_data;
    logic             r_skid_valid;
    dfr_pkg::t_result r_skid_data;
    logic             w_pop;

    // A transfer on the output side frees the output register.
    assign w_pop   = r_out_valid && o_out.ready;
    // A new result can always be held while the skid register is empty.
    assign o_ready = !r_skid_valid;

    // Control state of the two entries.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || w_pop) begin
            r_out_valid  <= r_skid_valid || i_push;
            r_skid_valid <= r_skid_valid && i_push;
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Payload of the two entries.
    always_ff @(posedge i_clk) begin
        if (!r_out_valid || w_pop) begin
            r_out_data <= r_skid_valid ? r_skid_data : i_data;
            if (r_skid_valid && i_push) begin
                r_skid_data <= i_data;
            end
        end else if (i_push) begin
            r_skid_data <= i_data;
        end
    end

    // Drive the output channel.
    assign o_out.valid       = r_out_valid;
    assign o_out.frame_ready = r_out_data.frame_ready;
    assign o_out.payload_0   = r_out_data.payload[0];
    assign o_out.payload_1   = r_out_data.payload[1];
    assign o_out.payload_2   = r_out_data.payload[2];
    assign o_out.payload_3   = r_out_data.payload[3];
    assign o_out.payload_4   = r_out_data.payload[4];
    assign o_out.payload_5   = r_out_data.payload[5];

    // The skid register is only occupied behind a waiting output register.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held without an output entry");

    // A stalled output entry keeps its frame.
    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |=> (r_out_valid && $stable(r_out_data)))
        else $error("stalled output entry changed");

    // No result is pushed while both entries are occupied and the output entry does not transfer.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && r_skid_valid && !w_pop))
        else $error("result pushed into a full buffer");

endmodule

`default_nettype wire

// ----- design/delimited_frame_receiver.sv -----
// Top level of the start/end byte delimited frame receiver.
// Throughput: one input item per cycle; input ready drops only while both output entries are full.
// A tick on an ended frame pushes the frame into the registered output buffer.
// The per-item update is a single pass of compare, count and store-write logic on the state.
// Reset (synchronous, active low) restores the configuration defaults, returns to idle,
// zeroes the counters and the six-byte store at once, and empties the output buffer.
`default_nettype none

module delimited_frame_receiver (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_cfg_we,
    input  wire [dfr_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  wire [dfr_pkg::CFG_DATA_W-1:0]         i_cfg_data,
    dfr_in_if.sink                                i_in,
    dfr_out_if.source                             o_out
);

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_OPEN  = 2'd1,
        PH_ENDED = 2'd2,
        PH_ERROR = 2'd3
    } t_phase;

    // Configuration registers.
    dfr_pkg::t_byte r_start_code;
    dfr_pkg::t_byte r_end_code;
    dfr_pkg::t_byte r_timeout_limit;

    // Frame state.
    t_phase                                r_phase, n_phase;
    logic [dfr_pkg::COUNT_W-1:0]           r_byte_count, n_byte_count;
    logic [7:0]                            r_hold_ticks, n_hold_ticks;
    logic [dfr_pkg::FRAME_BYTES-1:0][7:0]  r_store, n_store;

    logic             w_accept;
    logic             w_push;
    logic             w_buf_ready;
    logic [7:0]       w_hold_inc;
    dfr_pkg::t_result w_result;

    assign w_accept   = i_in.valid && i_in.ready;
    assign i_in.ready = w_buf_ready;
    assign w_hold_inc = r_hold_ticks + 8'd1;

    // Configuration writes; an index past the last register is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_code    <= dfr_pkg::START_CODE_RST;
            r_end_code      <= dfr_pkg::END_CODE_RST;
            r_timeout_limit <= dfr_pkg::TIMEOUT_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                dfr_pkg::CFG_START_CODE:    r_start_code    <= i_cfg_data;
                dfr_pkg::CFG_END_CODE:      r_end_code      <= i_cfg_data;
                dfr_pkg::CFG_TIMEOUT_LIMIT: r_timeout_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Next frame state for the accepted item.
    always_comb begin
        n_phase      = r_phase;
        n_byte_count = r_byte_count;
        n_hold_ticks = r_hold_ticks;
        n_store      = r_store;
        w_push       = 1'b0;
        if (w_accept) begin
            if (i_in.func == dfr_pkg::FUNC_BYTE) begin
                case (r_phase)
                    PH_IDLE: begin
                        if (i_in.rx_byte == r_start_code) begin
                            n_phase      = PH_OPEN;
                            n_byte_count = '0;
                        end
                    end
                    PH_OPEN: begin
                        if (i_in.rx_byte == r_end_code) begin
                            n_phase = PH_ENDED;
                        end else if (r_byte_count >= dfr_pkg::COUNT_W'(dfr_pkg::FRAME_BYTES)) begin
                            n_phase = PH_ERROR;
                        end else begin
                            for (int i = 0; i < dfr_pkg::FRAME_BYTES; i++) begin
                                if (r_byte_count == dfr_pkg::COUNT_W'(i)) begin
                                    n_store[i] = i_in.rx_byte;
                                end
                            end
                            n_byte_count = r_byte_count + dfr_pkg::COUNT_W'(1);
                        end
                    end
                    default: ;
                endcase
            end else begin
                case (r_phase)
                    PH_IDLE: begin
                        n_hold_ticks = '0;
                    end
                    PH_OPEN: begin
                        // Abandon the frame once the hold time exceeds the limit.
                        if (w_hold_inc > r_timeout_limit) begin
                            n_hold_ticks = '0;
                            n_phase      = PH_IDLE;
                        end else begin
                            n_hold_ticks = w_hold_inc;
                        end
                    end
                    PH_ERROR: begin
                        n_store = '0;
                        n_phase = PH_IDLE;
                    end
                    PH_ENDED: begin
                        w_push  = 1'b1;
                        n_store = '0;
                        n_phase = PH_IDLE;
                    end
                    default: ;
                endcase
            end
        end
    end

    // Frame state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_byte_count <= '0;
            r_hold_ticks <= '0;
            r_store      <= '0;
        end else begin
            r_phase      <= n_phase;
            r_byte_count <= n_byte_count;
            r_hold_ticks <= n_hold_ticks;
            r_store      <= n_store;
        end
    end

    // The handed-over frame is the store as it stands at the tick.
    assign w_result.frame_ready = 1'b1;
    assign w_result.payload     = r_store;

    dfr_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_result),
        .o_ready (w_buf_ready),
        .o_out   (o_out)
    );

    // The byte count never passes the frame size.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_count <= dfr_pkg::COUNT_W'(dfr_pkg::FRAME_BYTES))
        else $error("byte count beyond frame size");

    // A tick on an ended frame hands it over and leaves an empty store.
    a_ended_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in.func == dfr_pkg::FUNC_TICK && r_phase == PH_ENDED)
        |=> (r_store == '0 && r_phase == PH_IDLE))
        else $error("ended frame not cleared after hand-over");

    // Results come only from ticks on ended frames.
    a_push_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> (w_accept && i_in.func == dfr_pkg::FUNC_TICK && r_phase == PH_ENDED))
        else $error("result pushed without an ended frame");

endmodule

`default_nettype wire
